// File: src/kfli_pkg.sv
// shared constants, types and saturation helpers for the keyframe interpolator
`timescale 1ns / 1ps
package kfli_pkg;

  localparam int VALUE_WIDTH = 24;
  localparam int MAX_KEYS    = 32;
  localparam int CHANNELS    = 3;
  localparam int FRAC_BITS   = 8;
  localparam int STEP_W      = 10;
  localparam int KEY_AW      = $clog2(MAX_KEYS);
  localparam int CNT_W       = $clog2(MAX_KEYS + 1);
  localparam int KEY_W       = CHANNELS * VALUE_WIDTH;
  localparam int CMD_W       = 3;
  localparam int CH_W        = 2;

  localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(90);

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RECORD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UP     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd4;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [VALUE_WIDTH:0]   wide_t;

  localparam value_t VALUE_ONE = value_t'(1 << FRAC_BITS);
  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // clamp a one-bit-wider value into the value range
  function automatic value_t sat_trim(input wide_t v);
    value_t r;
    if (v[VALUE_WIDTH] != v[VALUE_WIDTH-1]) begin
      r = v[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
    end else begin
      r = v[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic value_t sat_add(input value_t a, input value_t b);
    wide_t s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    return sat_trim(s);
  endfunction

endpackage

// File: src/keyframe_linear_interpolator_core.sv
// top level of the three-channel keyframe player
`timescale 1ns / 1ps
// Commands are taken when start is high and busy is low; each command returns one word on
// the output ports, flagged by done for a single cycle, in the cycle after acceptance for
// tick, record, nudge and stop commands. A play start, and a tick that moves on to a new
// segment, read two keys from the key memory and run three bit-serial dividers in parallel,
// one quotient bit per cycle, passing through S_RD_A, S_RD_B, S_RD_C and S_DIV before done.
// The receiver cannot stall; results are shown once and must be taken then.
module keyframe_linear_interpolator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [kfli_pkg::CMD_W-1:0]   cmd,
  input  logic [kfli_pkg::CH_W-1:0]    channel,
  input  logic                         cfg_write,
  input  logic [kfli_pkg::STEP_W-1:0]  cfg_data,
  output logic                         done,
  output kfli_pkg::value_t             value_a,
  output kfli_pkg::value_t             value_b,
  output kfli_pkg::value_t             value_c,
  output logic                         playing,
  output logic [kfli_pkg::KEY_AW-1:0]  segment,
  output logic [kfli_pkg::CNT_W-1:0]   keys_stored,
  output logic                         refused
);
  import kfli_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD_A = 5'b00010,
    S_RD_B = 5'b00100,
    S_RD_C = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  state_t            state;
  value_t            live     [CHANNELS];
  value_t            inc      [CHANNELS];
  value_t            key_a    [CHANNELS];
  value_t            quot     [CHANNELS];
  wide_t             diff     [CHANNELS];
  logic              div_done [CHANNELS];
  logic [CNT_W-1:0]  key_count;
  logic [KEY_AW-1:0] seg;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] eff_steps;
  logic              play;
  logic              load_live;
  logic [KEY_AW-1:0] key_idx;

  logic              accept;
  logic              ram_we;
  logic [KEY_AW-1:0] raddr;
  logic [KEY_W-1:0]  rdata;
  logic [CNT_W-1:0]  seg_inc;
  logic              seg_end;
  logic              div_load;

  assign accept    = start && (state == S_IDLE);
  assign busy      = state != S_IDLE;
  assign eff_steps = (steps == '0) ? STEP_W'(1) : steps;
  assign ram_we    = accept && (cmd == CMD_RECORD) && (key_count < CNT_W'(MAX_KEYS));
  assign raddr     = (state == S_RD_A) ? key_idx : key_idx + KEY_AW'(1);
  assign seg_inc   = CNT_W'(seg) + CNT_W'(1);
  assign seg_end   = ({1'b0, seg_inc} + (CNT_W+1)'(2)) > {1'b0, key_count};
  assign div_load  = state == S_RD_C;

  kfli_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_KEYS)
  ) u_keys (
    .clk  (clk),
    .we   (ram_we),
    .waddr(key_count[KEY_AW-1:0]),
    .wdata({live[2], live[1], live[0]}),
    .raddr(raddr),
    .rdata(rdata)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    value_t key_b;
    assign key_b   = rdata[c*VALUE_WIDTH +: VALUE_WIDTH];
    assign diff[c] = {key_b[VALUE_WIDTH-1], key_b} - {key_a[c][VALUE_WIDTH-1], key_a[c]};

    kfli_div u_div (
      .clk     (clk),
      .rst     (rst),
      .load    (div_load),
      .dividend(diff[c]),
      .divisor (eff_steps),
      .done    (div_done[c]),
      .quotient(quot[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= STEPS_RESET;
    end else if (cfg_write) begin
      steps <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      refused   <= 1'b0;
      play      <= 1'b0;
      key_count <= '0;
      seg       <= '0;
      step_cnt  <= '0;
      load_live <= 1'b0;
      key_idx   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        live[c] <= '0;
        inc[c]  <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            refused <= 1'b0;
            done    <= 1'b1;
            case (cmd)
              CMD_TICK: begin
                if (play) begin
                  if (step_cnt >= eff_steps) begin
                    if (seg_end) begin
                      seg  <= '0;
                      play <= 1'b0;
                    end else begin
                      seg       <= seg_inc[KEY_AW-1:0];
                      step_cnt  <= '0;
                      key_idx   <= seg_inc[KEY_AW-1:0];
                      load_live <= 1'b0;
                      done      <= 1'b0;
                      state     <= S_RD_A;
                    end
                  end else begin
                    for (int c = 0; c < CHANNELS; c++) begin
                      live[c] <= sat_add(live[c], inc[c]);
                    end
                    step_cnt <= step_cnt + STEP_W'(1);
                  end
                end
              end
              CMD_RECORD: begin
                if (key_count < CNT_W'(MAX_KEYS)) begin
                  key_count <= key_count + CNT_W'(1);
                end else begin
                  refused <= 1'b1;
                end
              end
              CMD_PLAY: begin
                if (!play && key_count >= CNT_W'(2)) begin
                  seg       <= '0;
                  step_cnt  <= '0;
                  play      <= 1'b1;
                  key_idx   <= '0;
                  load_live <= 1'b1;
                  done      <= 1'b0;
                  state     <= S_RD_A;
                end else begin
                  refused <= !play;
                  play    <= 1'b0;
                end
              end
              CMD_UP: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (channel == CH_W'(c)) begin
                    live[c] <= sat_add(live[c], VALUE_ONE);
                  end
                end
              end
              CMD_DOWN: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (channel == CH_W'(c)) begin
                    live[c] <= sat_add(live[c], -VALUE_ONE);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD_A: begin
          state <= S_RD_B;
        end
        S_RD_B: begin
          for (int c = 0; c < CHANNELS; c++) begin
            key_a[c] <= rdata[c*VALUE_WIDTH +: VALUE_WIDTH];
            if (load_live) begin
              live[c] <= rdata[c*VALUE_WIDTH +: VALUE_WIDTH];
            end
          end
          state <= S_RD_C;
        end
        S_RD_C: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done[0]) begin
            for (int c = 0; c < CHANNELS; c++) begin
              inc[c] <= quot[c];
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign value_a     = live[0];
  assign value_b     = live[1];
  assign value_c     = live[2];
  assign playing     = play;
  assign segment     = seg;
  assign keys_stored = key_count;

endmodule

// File: src/kfli_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module kfli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/kfli_div.sv
// bit-serial signed divider by the step count, result saturated to the value range
`timescale 1ns / 1ps
module kfli_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  kfli_pkg::wide_t            dividend,
  input  logic [kfli_pkg::STEP_W-1:0] divisor,
  output logic                       done,
  output kfli_pkg::value_t           quotient
);
  import kfli_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic                   active;
  logic [CW-1:0]          cnt;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [STEP_W-1:0]      rem;
  logic [STEP_W-1:0]      dsr;
  logic [STEP_W:0]        shifted;
  logic                   fits;
  wide_t                  abs_in;
  wide_t                  q_signed;

  assign abs_in   = dividend[VALUE_WIDTH] ? -dividend : dividend;
  assign shifted  = {rem, mag[VALUE_WIDTH-1]};
  assign fits     = shifted >= {1'b0, dsr};
  assign q_signed = neg ? -{1'b0, mag} : {1'b0, mag};
  assign quotient = sat_trim(q_signed);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        active <= 1'b1;
        cnt    <= CW'(VALUE_WIDTH);
      end else if (active) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= dividend[VALUE_WIDTH];
      mag <= abs_in[VALUE_WIDTH-1:0];
      rem <= '0;
      dsr <= divisor;
    end else if (active) begin
      if (fits) begin
        rem <= STEP_W'(shifted - {1'b0, dsr});
        mag <= {mag[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[STEP_W-1:0];
        mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule
